FILE: rtl/mcs_pkg.sv
// ----------------------------------------------------------------------------
// mcs_pkg
// Shared types and constants for the min/max contrast stretch unit.
// ----------------------------------------------------------------------------
package mcs_pkg;

   localparam int PIXEL_W   = 8;
   localparam int NUM_W     = 2 * PIXEL_W;
   localparam int DIV_STEPS = NUM_W;
   localparam int CNT_W     = $clog2(DIV_STEPS);
   localparam int USER_W    = 2;

   localparam logic [PIXEL_W-1:0] FULL_SCALE = 8'd255;
   localparam logic [CNT_W-1:0]   LAST_STEP  = CNT_W'(DIV_STEPS - 1);

   // tuser bit positions
   localparam int USER_CMD_BIT   = 0;
   localparam int USER_START_BIT = 1;

   // command codes
   localparam logic CMD_MEASURE = 1'b0;
   localparam logic CMD_SCALE   = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV,
      ST_HOLD
   } state_type;

   typedef struct packed {
      logic measure;   // update min/max from the input beat
      logic start;     // load numerator and divisor for a scale beat
      logic div_step;  // one restoring division step
      logic out_load;  // move finished quotient to the output register
   } ctrl_cmd_type;

   typedef struct packed {
      logic out_free;  // output register empty or being drained this cycle
   } ctrl_sts_type;

endpackage

FILE: rtl/mcs_datapath.sv
// ----------------------------------------------------------------------------
// mcs_datapath
// Min/max tracking, numerator set-up, restoring divider and output register.
// ----------------------------------------------------------------------------
module mcs_datapath
   import mcs_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  ctrl_cmd_type        cmd,
   output ctrl_sts_type        sts,
   input  logic [PIXEL_W-1:0]  pixel,
   input  logic                frame_start,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [PIXEL_W-1:0]  rsp_tdata
);

   logic [PIXEL_W-1:0] low_seen_ff, low_seen_in;
   logic [PIXEL_W-1:0] high_seen_ff, high_seen_in;
   logic [NUM_W-1:0]   num_ff, num_in;
   logic [PIXEL_W-1:0] rem_ff, rem_in;
   logic [PIXEL_W-1:0] divisor_ff, divisor_in;
   logic               zero_ff, zero_in;
   logic [PIXEL_W-1:0] rsp_data_ff, rsp_data_in;
   logic               rsp_valid_ff, rsp_valid_in;

   logic [PIXEL_W-1:0] diff;
   logic [PIXEL_W:0]   rem_shift;
   logic               fits;
   logic [PIXEL_W:0]   rem_sub;
   logic [PIXEL_W-1:0] result;

   assign diff      = pixel - low_seen_ff;
   assign rem_shift = {rem_ff, num_ff[NUM_W-1]};
   assign fits      = rem_shift >= {1'b0, divisor_ff};
   assign rem_sub   = rem_shift - {1'b0, divisor_ff};

   // quotient above full scale saturates
   assign result = zero_ff ? '0
                 : (|num_ff[NUM_W-1:PIXEL_W]) ? FULL_SCALE : num_ff[PIXEL_W-1:0];

   assign sts.out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      low_seen_in  = low_seen_ff;
      high_seen_in = high_seen_ff;
      num_in       = num_ff;
      rem_in       = rem_ff;
      divisor_in   = divisor_ff;
      zero_in      = zero_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;

      if (cmd.measure) begin
         if (frame_start) begin
            low_seen_in  = pixel;
            high_seen_in = pixel;
         end else begin
            if (pixel < low_seen_ff) begin
               low_seen_in = pixel;
            end
            if (pixel > high_seen_ff) begin
               high_seen_in = pixel;
            end
         end
      end

      if (cmd.start) begin
         // (pixel - min) * 255 as (d << 8) - d
         num_in     = {diff, {PIXEL_W{1'b0}}} - {{PIXEL_W{1'b0}}, diff};
         rem_in     = '0;
         divisor_in = high_seen_ff - low_seen_ff;
         zero_in    = (high_seen_ff <= low_seen_ff) || (pixel <= low_seen_ff);
      end

      if (cmd.div_step) begin
         num_in = {num_ff[NUM_W-2:0], fits};
         rem_in = fits ? rem_sub[PIXEL_W-1:0] : rem_shift[PIXEL_W-1:0];
      end

      if (cmd.out_load) begin
         rsp_data_in  = result;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         low_seen_ff  <= '0;
         high_seen_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         low_seen_ff  <= low_seen_in;
         high_seen_ff <= high_seen_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff      <= num_in;
      rem_ff      <= rem_in;
      divisor_ff  <= divisor_in;
      zero_ff     <= zero_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_range_ordered: assert property (@(posedge clock) disable iff (reset)
      low_seen_ff <= high_seen_ff)
      else $error("stored minimum above stored maximum");

   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |=> rsp_valid_ff)
      else $error("result load did not raise rsp_tvalid");

   a_remainder_bound: assert property (@(posedge clock) disable iff (reset)
      $past(cmd.div_step) && !zero_ff |-> rem_ff < divisor_ff)
      else $error("divider remainder not below divisor");

endmodule

FILE: rtl/mcs_controller.sv
// ----------------------------------------------------------------------------
// mcs_controller
// Sequencer: accepts beats, runs the divider steps, hands off the result.
// ----------------------------------------------------------------------------
module mcs_controller
   import mcs_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic          command,
   output ctrl_cmd_type  cmd,
   input  ctrl_sts_type  sts
);

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] step_ff, step_in;
   logic             accept;

   assign accept = req_tvalid && req_tready;

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      req_tready   = 1'b0;
      cmd          = '0;

      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (accept) begin
               if (command == CMD_SCALE) begin
                  cmd.start = 1'b1;
                  step_in   = '0;
                  state_in  = ST_DIV;
               end else begin
                  cmd.measure = 1'b1;
               end
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            step_in      = step_ff + 1'b1;
            if (step_ff == LAST_STEP) begin
               state_in = ST_HOLD;
            end
         end
         ST_HOLD: begin
            if (sts.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   a_scale_starts_div: assert property (@(posedge clock) disable iff (reset)
      accept && command == CMD_SCALE |=> state_ff == ST_DIV && step_ff == '0)
      else $error("scale beat did not start the divider");

   a_div_length: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIV && step_ff == LAST_STEP |=> state_ff == ST_HOLD)
      else $error("divider did not finish after its last step");

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> sts.out_free)
      else $error("result loaded over a pending output beat");

endmodule

FILE: rtl/minmax_contrast_stretch_unit.sv
// ----------------------------------------------------------------------------
// minmax_contrast_stretch_unit
// Two-pass min/max contrast stretch of 8-bit grayscale pixels.
// ----------------------------------------------------------------------------
// The host sends each frame twice on the req channel. tuser[0] picks the
// command: measure beats (0) widen the stored min/max range, and the beat
// with tuser[1] set loads both bounds from its pixel. Scale beats (1) return
// one rsp beat holding (pixel - min) * 255 / (max - min), truncated and
// saturated at 255; it is 0 when the range is empty or the pixel is at or
// below the minimum.
// A measure beat leaves the sequencer in ST_IDLE, so measure beats stream
// back to back. A scale beat holds off the next beat: its accepting cycle
// sets up the numerator, sixteen steps of the restoring divider follow and
// ST_HOLD then moves the quotient into the output register once that is
// free, from where the result shows on rsp.
// The output register parts the two sides: a stalled rsp beat does not stop
// measure beats or the next division; only the hand-off of a second result
// waits until the pending one is taken.
// Reset clears min and max to 0 and empties the output register.
// ----------------------------------------------------------------------------
module minmax_contrast_stretch_unit
   import mcs_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [PIXEL_W-1:0]  req_tdata,   // [7:0] pixel
   input  logic [USER_W-1:0]   req_tuser,   // [0] command, [1] frame_start
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [PIXEL_W-1:0]  rsp_tdata    // [7:0] scaled_pixel
);

   ctrl_cmd_type cmd;
   ctrl_sts_type sts;

   mcs_controller u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .command    (req_tuser[USER_CMD_BIT]),
      .cmd        (cmd),
      .sts        (sts)
   );

   mcs_datapath u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .sts         (sts),
      .pixel       (req_tdata),
      .frame_start (req_tuser[USER_START_BIT]),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata)
   );

endmodule
